// File: src/tsqm_pkg.sv
`default_nettype none

package tsqm_pkg;

    localparam int ID_W    = 16;
    localparam int CNT_W   = 16;
    localparam int INTV_W  = 8;
    localparam int SLOT_W  = 3;
    localparam int LIVE_W  = 4;

    localparam logic [INTV_W-1:0] INTV_RESET = 8'd16;

    localparam logic [1:0] CMD_STORE   = 2'd0;
    localparam logic [1:0] CMD_SENT    = 2'd1;
    localparam logic [1:0] CMD_DISCARD = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic idx_clr;
        logic idx_inc;
        logic rd_slot;
        logic sum_rd;
        logic set_bad;
        logic set_full;
        logic do_store;
        logic do_act;
        logic out_load;
    } tsqm_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       pcount_zero;
        logic       slot_bad;
        logic       idx_live;
        logic       idx_last;
        logic       out_free;
    } tsqm_stat_t;

endpackage

`default_nettype wire

// File: src/tsqm_ctrl.sv
`default_nettype none

module tsqm_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tsqm_pkg::tsqm_stat_t stat,
    output tsqm_pkg::tsqm_cmd_t     cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_ACT   = 3'd4;
    localparam logic [2:0] S_SUM   = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = aresetn && (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC: begin
                case (stat.command)
                    tsqm_pkg::CMD_STORE: begin
                        if (stat.pcount_zero) begin
                            cmd.set_bad = 1'b1;
                            state_next  = S_SUM;
                        end else begin
                            state_next  = S_FREE;
                        end
                    end
                    tsqm_pkg::CMD_SENT, tsqm_pkg::CMD_DISCARD: begin
                        if (stat.slot_bad) begin
                            cmd.set_bad = 1'b1;
                            state_next  = S_SUM;
                        end else begin
                            state_next  = S_READ;
                        end
                    end
                    default: begin
                        state_next = S_SUM;
                    end
                endcase
            end
            S_FREE: begin
                if (!stat.idx_live) begin
                    cmd.do_store = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_SUM;
                end else if (stat.idx_last) begin
                    cmd.set_full = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_SUM;
                end else begin
                    cmd.idx_inc  = 1'b1;
                end
            end
            S_READ: begin
                cmd.rd_slot = 1'b1;
                state_next  = S_ACT;
            end
            S_ACT: begin
                cmd.do_act  = 1'b1;
                cmd.idx_clr = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM: begin
                cmd.sum_rd  = 1'b1;
                cmd.idx_inc = 1'b1;
                if (stat.idx_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/tsqm_dp.sv
`default_nettype none

module tsqm_dp #(
    parameter int SLOTS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire tsqm_pkg::tsqm_cmd_t                cmd,
    output tsqm_pkg::tsqm_stat_t                    stat,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tsqm_pkg::INTV_W-1:0]        cfg_wr_data,
    input  wire logic [1:0]                         s_command,
    input  wire logic [tsqm_pkg::SLOT_W-1:0]        s_slot,
    input  wire logic [tsqm_pkg::CNT_W-1:0]         s_packet_count,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_status,
    output logic [tsqm_pkg::SLOT_W-1:0]             m_slot_used,
    output logic [tsqm_pkg::ID_W-1:0]               m_item_id,
    output logic                                    m_completed,
    output logic                                    m_checkpoint,
    output logic                                    m_oldest_valid,
    output logic [tsqm_pkg::SLOT_W-1:0]             m_oldest_slot,
    output logic                                    m_newest_valid,
    output logic [tsqm_pkg::SLOT_W-1:0]             m_newest_slot,
    output logic [tsqm_pkg::LIVE_W-1:0]             m_live_count,
    output logic [tsqm_pkg::CNT_W-1:0]              m_remaining_total,
    output logic                                    m_free_available
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int ID_W  = tsqm_pkg::ID_W;
    localparam int CNT_W = tsqm_pkg::CNT_W;
    localparam int INTV_W = tsqm_pkg::INTV_W;

    logic [ID_W+CNT_W-1:0] mem [SLOTS];
    logic [ID_W+CNT_W-1:0] rdata_reg;

    logic [1:0]          cmd_reg;
    logic [2:0]          slot_reg;
    logic [CNT_W-1:0]    pcount_reg;
    logic [IW-1:0]       idx_reg;
    logic [SLOTS-1:0]    live_reg;
    logic [ID_W-1:0]     next_id_reg;
    logic [INTV_W-1:0]   psc_reg;
    logic [INTV_W-1:0]   intv_reg;

    logic [1:0]          status_reg;
    logic [2:0]          slot_used_reg;
    logic [ID_W-1:0]     item_reg;
    logic                completed_reg;
    logic                ckpt_reg;

    logic                acc_pend_reg;
    logic [IW-1:0]       acc_idx_reg;
    logic [CW-1:0]       live_cnt_reg;
    logic [CNT_W-1:0]    total_reg;
    logic                found_reg;
    logic [IW-1:0]       old_idx_reg;
    logic [ID_W-1:0]     old_id_reg;
    logic [IW-1:0]       new_idx_reg;
    logic [ID_W-1:0]     new_id_reg;

    logic                m_valid_reg;

    logic [IW-1:0]       slot_idx;
    logic [IW-1:0]       rd_addr;
    logic [ID_W-1:0]     rd_id;
    logic [CNT_W-1:0]    rd_cnt;
    logic [CNT_W-1:0]    cnt_dec;
    logic [INTV_W-1:0]   psc_inc;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [ID_W+CNT_W-1:0] wr_data;
    logic [CNT_W:0]      total_sum;
    logic [ID_W-1:0]     d_old;
    logic [ID_W-1:0]     d_new;
    logic                acc_live;

    assign slot_idx = IW'(slot_reg);
    assign rd_addr  = cmd.rd_slot ? slot_idx : idx_reg;
    assign rd_id    = rdata_reg[ID_W+CNT_W-1:CNT_W];
    assign rd_cnt   = rdata_reg[CNT_W-1:0];
    assign cnt_dec  = rd_cnt - CNT_W'(1);
    assign psc_inc  = psc_reg + INTV_W'(1);

    assign wr_en   = cmd.do_store || (cmd.do_act && (cmd_reg == tsqm_pkg::CMD_SENT));
    assign wr_addr = cmd.do_store ? idx_reg : slot_idx;
    assign wr_data = cmd.do_store ? {next_id_reg, pcount_reg} : {rd_id, cnt_dec};

    assign acc_live  = acc_pend_reg && live_reg[acc_idx_reg];
    assign total_sum = {1'b0, total_reg} + {1'b0, rd_cnt};
    assign d_old     = rd_id - old_id_reg;
    assign d_new     = rd_id - new_id_reg;

    assign stat.command     = cmd_reg;
    assign stat.pcount_zero = (pcount_reg == '0);
    assign stat.slot_bad    = (32'(slot_reg) >= SLOTS) || !live_reg[slot_idx];
    assign stat.idx_live    = live_reg[idx_reg];
    assign stat.idx_last    = (idx_reg == IW'(SLOTS - 1));
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg    <= s_command;
            slot_reg   <= s_slot;
            pcount_reg <= s_packet_count;
        end
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + IW'(1);
        end
        acc_idx_reg <= idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg     <= '0;
            next_id_reg  <= '0;
            psc_reg      <= '0;
            intv_reg     <= tsqm_pkg::INTV_RESET;
            acc_pend_reg <= 1'b0;
        end else begin
            acc_pend_reg <= cmd.sum_rd;
            if (cfg_wr_en) begin
                intv_reg <= cfg_wr_data;
            end
            if (cmd.do_store) begin
                live_reg[idx_reg] <= 1'b1;
                next_id_reg       <= next_id_reg + ID_W'(1);
            end
            if (cmd.do_act) begin
                if (cmd_reg == tsqm_pkg::CMD_DISCARD) begin
                    live_reg[slot_idx] <= 1'b0;
                end else if (cnt_dec == '0) begin
                    live_reg[slot_idx] <= 1'b0;
                    psc_reg            <= '0;
                end else if (psc_inc >= intv_reg) begin
                    psc_reg <= '0;
                end else begin
                    psc_reg <= psc_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            status_reg    <= tsqm_pkg::STATUS_OK;
            slot_used_reg <= '0;
            item_reg      <= '0;
            completed_reg <= 1'b0;
            ckpt_reg      <= 1'b0;
        end else begin
            if (cmd.set_bad) begin
                status_reg <= tsqm_pkg::STATUS_BAD;
            end
            if (cmd.set_full) begin
                status_reg <= tsqm_pkg::STATUS_FULL;
            end
            if (cmd.do_store) begin
                slot_used_reg <= 3'(idx_reg);
                item_reg      <= next_id_reg;
                ckpt_reg      <= 1'b1;
            end
            if (cmd.do_act) begin
                item_reg <= rd_id;
                if (cmd_reg == tsqm_pkg::CMD_DISCARD) begin
                    ckpt_reg <= 1'b1;
                end else if (cnt_dec == '0) begin
                    completed_reg <= 1'b1;
                    ckpt_reg      <= 1'b1;
                end else if (psc_inc >= intv_reg) begin
                    ckpt_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            live_cnt_reg <= '0;
            total_reg    <= '0;
            found_reg    <= 1'b0;
            old_idx_reg  <= '0;
            old_id_reg   <= '0;
            new_idx_reg  <= '0;
            new_id_reg   <= '0;
        end else if (acc_live) begin
            live_cnt_reg <= live_cnt_reg + CW'(1);
            total_reg    <= total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];
            found_reg    <= 1'b1;
            if (!found_reg || d_old[ID_W-1]) begin
                old_idx_reg <= acc_idx_reg;
                old_id_reg  <= rd_id;
            end
            if (!found_reg || ((d_new != '0) && !d_new[ID_W-1])) begin
                new_idx_reg <= acc_idx_reg;
                new_id_reg  <= rd_id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status          <= status_reg;
            m_slot_used       <= slot_used_reg;
            m_item_id         <= item_reg;
            m_completed       <= completed_reg;
            m_checkpoint      <= ckpt_reg;
            m_oldest_valid    <= found_reg;
            m_oldest_slot     <= 3'(old_idx_reg);
            m_newest_valid    <= found_reg;
            m_newest_slot     <= 3'(new_idx_reg);
            m_live_count      <= 4'(live_cnt_reg);
            m_remaining_total <= total_reg;
            m_free_available  <= (live_cnt_reg != CW'(SLOTS));
        end
    end

endmodule

`default_nettype wire

// File: src/transmit_slot_queue_manager.sv
`default_nettype none

// Transmit slot queue manager: a table of SLOTS entries, each an item id and a
// count of packets still to send. One command is taken at a time: store (lowest
// free slot, next rolling id), packet sent, discard or query. Each command
// returns one result with the action outcome plus the oldest and newest live
// slots, live count, saturated remaining total and free-slot flag. Each item
// is handled by a single-port scan over the slot memory, one slot per cycle,
// for the free-slot search of a store and for the summary pass. s_ready is
// high while the controller is idle; a finished result waits in the output
// register while the next command is taken. The checkpoint interval is
// written through cfg_wr_en/cfg_wr_data.

module transmit_slot_queue_manager #(
    parameter int SLOTS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tsqm_pkg::INTV_W-1:0]        cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [1:0]                         s_command,
    input  wire logic [tsqm_pkg::SLOT_W-1:0]        s_slot,
    input  wire logic [tsqm_pkg::CNT_W-1:0]         s_packet_count,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_status,
    output logic [tsqm_pkg::SLOT_W-1:0]             m_slot_used,
    output logic [tsqm_pkg::ID_W-1:0]               m_item_id,
    output logic                                    m_completed,
    output logic                                    m_checkpoint,
    output logic                                    m_oldest_valid,
    output logic [tsqm_pkg::SLOT_W-1:0]             m_oldest_slot,
    output logic                                    m_newest_valid,
    output logic [tsqm_pkg::SLOT_W-1:0]             m_newest_slot,
    output logic [tsqm_pkg::LIVE_W-1:0]             m_live_count,
    output logic [tsqm_pkg::CNT_W-1:0]              m_remaining_total,
    output logic                                    m_free_available
);

    tsqm_pkg::tsqm_cmd_t  cmd;
    tsqm_pkg::tsqm_stat_t stat;

    tsqm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tsqm_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_command         (s_command),
        .s_slot            (s_slot),
        .s_packet_count    (s_packet_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_slot_used       (m_slot_used),
        .m_item_id         (m_item_id),
        .m_completed       (m_completed),
        .m_checkpoint      (m_checkpoint),
        .m_oldest_valid    (m_oldest_valid),
        .m_oldest_slot     (m_oldest_slot),
        .m_newest_valid    (m_newest_valid),
        .m_newest_slot     (m_newest_slot),
        .m_live_count      (m_live_count),
        .m_remaining_total (m_remaining_total),
        .m_free_available  (m_free_available)
    );

endmodule

`default_nettype wire
